>>> src/mhw_pkg.sv
// ----------------------------------------------------------------------------
// mhw_pkg
// Shared types and codes of the multichannel heartbeat watchdog.
// ----------------------------------------------------------------------------
package mhw_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned CountW  = 8;
  localparam int unsigned FuncW   = 3;
  localparam int unsigned ChanW   = 3;
  localparam int unsigned ActW    = 2;
  localparam int unsigned ResW    = 4;
  localparam logic [ResW-1:0] MaxResults = 4'd8;

  localparam logic [FuncW-1:0] FN_SETUP = 3'd0;
  localparam logic [FuncW-1:0] FN_BEAT  = 3'd1;
  localparam logic [FuncW-1:0] FN_SLOW  = 3'd2;
  localparam logic [FuncW-1:0] FN_HANG  = 3'd3;
  localparam logic [FuncW-1:0] FN_DECAY = 3'd4;

  localparam logic [ActW-1:0] ACT_LOG  = 2'd0;
  localparam logic [ActW-1:0] ACT_WAKE = 2'd1;
  localparam logic [ActW-1:0] ACT_TERM = 2'd2;

  typedef struct packed {
    logic              en;
    logic [TimeW-1:0]  last_beat;
    logic [TimeW-1:0]  slow_limit;
    logic [TimeW-1:0]  hang_delay;
    logic [CountW-1:0] wake_limit;
    logic [CountW-1:0] wake_count;
    logic              log_pending;
  } entry_t;

  localparam entry_t EntryRst = '{
    en:          1'b0,
    last_beat:   '0,
    slow_limit:  '1,
    hang_delay:  '1,
    wake_limit:  '1,
    wake_count:  '0,
    log_pending: 1'b0
  };

  typedef struct packed {
    logic [ActW-1:0]   act;
    logic [TimeW-1:0]  elapsed;
    logic              emit;
    logic              stop;
    logic              wr;
    entry_t            upd;
  } eval_t;

  typedef struct packed {
    logic [ChanW-1:0]  ch;
    logic [ActW-1:0]   act;
    logic [TimeW-1:0]  elapsed;
    logic [CountW-1:0] wc;
  } res_t;

endpackage

>>> src/mhw_ram.sv
// ----------------------------------------------------------------------------
// mhw_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module mhw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/mhw_eval.sv
// ----------------------------------------------------------------------------
// mhw_eval
// Per-channel check: overdue test, action choice and entry update.
// ----------------------------------------------------------------------------
module mhw_eval import mhw_pkg::*; (
  input  logic [FuncW-1:0] func_i,
  input  logic [TimeW-1:0] now_i,
  input  logic             suppress_i,
  input  entry_t           entry_i,
  output eval_t            eval_o
);

  logic [TimeW-1:0] lim;
  logic [TimeW:0]   sum;
  logic             od;
  logic             hit;
  logic             term;
  entry_t           upd;

  always_comb begin
    lim  = (func_i == FN_SLOW) ? entry_i.slow_limit : entry_i.hang_delay;
    sum  = {1'b0, entry_i.last_beat} + {1'b0, lim};
    od   = entry_i.en && ({1'b0, now_i} >= sum);
    term = (func_i == FN_HANG) && (entry_i.wake_count > entry_i.wake_limit);
    upd  = entry_i;
    hit  = 1'b0;
    unique case (func_i)
      FN_SLOW: begin
        hit             = od && !entry_i.log_pending;
        upd.log_pending = 1'b1;
      end
      FN_HANG: begin
        hit = od;
        if (entry_i.wake_count != '1) begin
          upd.wake_count = entry_i.wake_count + 1'b1;
        end
      end
      FN_DECAY: begin
        if (entry_i.wake_count != '0) begin
          upd.wake_count = entry_i.wake_count - 1'b1;
        end
        upd.log_pending = 1'b0;
      end
      default: begin
        hit = 1'b0;
      end
    endcase

    eval_o.act     = (func_i == FN_SLOW) ? ACT_LOG : (term ? ACT_TERM : ACT_WAKE);
    eval_o.elapsed = now_i - entry_i.last_beat;
    eval_o.emit    = hit && !suppress_i;
    eval_o.stop    = hit && (suppress_i || term);
    eval_o.wr      = (func_i == FN_DECAY) || (hit && !suppress_i && !term);
    eval_o.upd     = upd;
  end

endmodule

>>> src/multichannel_heartbeat_watchdog.sv
// ----------------------------------------------------------------------------
// multichannel_heartbeat_watchdog
// Per-channel heartbeat watchdog with slow logging and hang escalation.
// ----------------------------------------------------------------------------
// Setup and heartbeat: accept with RAM read, then write back.
// Checks and decay walk the channel RAM at one channel per cycle, except
// while a found action waits on a stalled result register.
// Each result leaves one found action later so its last flag is known.
// Reset clears the per-entry valid flops; unwritten entries read as reset
// values, so there is no clearing pass.
// ----------------------------------------------------------------------------
module multichannel_heartbeat_watchdog import mhw_pkg::*; #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [FuncW-1:0]  func_i,
  input  logic [ChanW-1:0]  channel_i,
  input  logic [TimeW-1:0]  time_value_i,
  input  logic              enable_bit_i,
  input  logic [TimeW-1:0]  slow_limit_in_i,
  input  logic [TimeW-1:0]  hang_delay_in_i,
  input  logic [CountW-1:0] wake_limit_in_i,
  input  logic              suppress_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ChanW-1:0]  out_channel_o,
  output logic [ActW-1:0]   action_o,
  output logic [TimeW-1:0]  elapsed_o,
  output logic [CountW-1:0] wake_count_out_o,
  output logic              last_flag_o
);

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(CHANNELS - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MOD   = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic [ResW-1:0]     n_q, n_d;
  logic [CHANNELS-1:0] vld_q, vld_d;
  logic                pend_vld_q, pend_vld_d;
  res_t                pend_q, pend_d;
  logic                out_vld_q, out_vld_d;
  res_t                out_q, out_d;
  logic                out_last_q, out_last_d;

  logic [FuncW-1:0]    func_q;
  logic [TimeW-1:0]    now_q;
  logic                sup_q;
  logic                en_q;
  logic [TimeW-1:0]    slow_q;
  logic [TimeW-1:0]    hang_q;
  logic [CountW-1:0]   wl_q;

  logic                accept;
  logic                chan_ok;
  logic [AW-1:0]       chan_addr;
  logic                out_free;

  logic                re;
  logic [AW-1:0]       raddr;
  logic                we;
  entry_t              wdata;
  logic [$bits(entry_t)-1:0] rdata;
  entry_t              entry;
  eval_t               ev;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign chan_ok   = {4'd0, channel_i} < 7'(CHANNELS);
  assign chan_addr = AW'(channel_i);
  assign out_free  = !out_vld_q || !out_stall_i;
  assign entry     = vld_q[idx_q] ? entry_t'(rdata) : EntryRst;

  mhw_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (idx_q),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  mhw_eval u_eval (
    .func_i     (func_q),
    .now_i      (now_q),
    .suppress_i (sup_q),
    .entry_i    (entry),
    .eval_o     (ev)
  );

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    n_d        = n_q;
    vld_d      = vld_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_d      = out_q;
    out_last_d = out_last_q;
    out_vld_d  = out_vld_q && out_stall_i;
    re         = 1'b0;
    raddr      = '0;
    we         = 1'b0;
    wdata      = entry;

    unique case (state_q)
      S_IDLE: begin
        n_d = '0;
        if (accept) begin
          if ((func_i == FN_SETUP || func_i == FN_BEAT) && chan_ok) begin
            re      = 1'b1;
            raddr   = chan_addr;
            idx_d   = chan_addr;
            state_d = S_MOD;
          end else if (func_i == FN_SLOW || func_i == FN_HANG ||
                       func_i == FN_DECAY) begin
            re      = 1'b1;
            raddr   = '0;
            idx_d   = '0;
            state_d = S_WALK;
          end
        end
      end
      S_MOD: begin
        we = 1'b1;
        if (func_q == FN_SETUP) begin
          wdata.en         = en_q;
          wdata.slow_limit = slow_q;
          wdata.hang_delay = hang_q;
          wdata.wake_limit = wl_q;
        end else begin
          wdata.last_beat = now_q;
        end
        vld_d[idx_q] = 1'b1;
        state_d      = S_IDLE;
      end
      S_WALK: begin
        if (!(ev.emit && pend_vld_q && !out_free)) begin
          we    = ev.wr;
          wdata = ev.upd;
          if (ev.wr) begin
            vld_d[idx_q] = 1'b1;
          end
          if (ev.emit) begin
            if (pend_vld_q) begin
              out_d      = pend_q;
              out_last_d = 1'b0;
              out_vld_d  = 1'b1;
            end
            pend_vld_d     = 1'b1;
            pend_d.ch      = ChanW'(idx_q);
            pend_d.act     = ev.act;
            pend_d.elapsed = ev.elapsed;
            pend_d.wc      = entry.wake_count;
            n_d            = n_q + 1'b1;
          end
          if (ev.stop || (ev.emit && n_q == MaxResults - 1'b1) || idx_q == LastIdx) begin
            state_d = S_FLUSH;
          end else begin
            re    = 1'b1;
            raddr = idx_q + 1'b1;
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_d      = pend_q;
          out_last_d = 1'b1;
          out_vld_d  = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      idx_q      <= '0;
      n_q        <= '0;
      vld_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      n_q        <= n_d;
      vld_q      <= vld_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
    if (accept) begin
      func_q <= func_i;
      now_q  <= time_value_i;
      sup_q  <= suppress_i;
      en_q   <= enable_bit_i;
      slow_q <= slow_limit_in_i;
      hang_q <= hang_delay_in_i;
      wl_q   <= wake_limit_in_i;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign out_channel_o    = out_q.ch;
  assign action_o         = out_q.act;
  assign elapsed_o        = out_q.elapsed;
  assign wake_count_out_o = out_q.wc;
  assign last_flag_o      = out_last_q;

endmodule
